[rtl/trpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trpd_pkg: shared types and constants
// Command and result codes, byte class boundaries and the result record that
// travels from the decode core to the output register.
// ----------------------------------------------------------------------------
package trpd_pkg;

  localparam int TRPD_MAX_ROWS = 64;
  localparam int TRPD_MIN_ROWS = 1;

  localparam int NUM_CH  = 3;
  localparam int ROW_W   = 7;
  localparam int KIND_W  = 4;

  // byte class boundaries
  localparam logic [7:0] B_NOTE_LAST   = 8'h5f;
  localparam logic [7:0] B_SAMPLE_LAST = 8'h6f;
  localparam logic [7:0] B_ORN_LAST    = 8'h7f;
  localparam logic [7:0] B_REST        = 8'h80;
  localparam logic [7:0] B_EMPTY       = 8'h81;
  localparam logic [7:0] B_ORN_ZERO    = 8'h82;
  localparam logic [7:0] B_ENV_LAST    = 8'h8e;
  localparam logic [7:0] B_PERIOD_BASE = 8'ha1;
  localparam logic [7:0] B_SAMPLE_BASE = 8'h60;
  localparam logic [7:0] B_ORN_BASE    = 8'h70;
  localparam logic [7:0] B_END         = 8'hff;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_ROW   = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    K_STARTED    = 4'd0,
    K_ROW        = 4'd1,
    K_NOTE       = 4'd2,
    K_SAMPLE     = 4'd3,
    K_ORNAMENT   = 4'd4,
    K_REST       = 4'd5,
    K_EMPTY      = 4'd6,
    K_ENVWAIT    = 4'd7,
    K_ENVELOPE   = 4'd8,
    K_PERIOD     = 4'd9,
    K_END        = 4'd10,
    K_FULL       = 4'd11,
    K_UNEXPECTED = 4'd12
  } kind_t;

  // class of one ordinary data byte
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       done;
    logic       env_type;
    logic       period_set;
  } byte_class_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        value;
    logic [7:0]        env_period;
    logic              channel_done;
    logic [NUM_CH-1:0] need_mask;
    logic [ROW_W-1:0]  row_number;
    logic [ROW_W-1:0]  pattern_length;
  } result_t;

endpackage
`default_nettype wire

[rtl/tracker_pattern_row_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tracker_pattern_row_decoder: three-channel pattern row decoder
// Decodes begin, row-start and data-byte items into classified row events.
// ----------------------------------------------------------------------------
// usage:
//   input stream (s_axis_*): one transfer per item; tuser carries the command
//   and channel, tdata the raw pattern byte
//   output stream (m_axis_*): exactly one result transfer per input transfer,
//   in order; tuser carries the result kind, tdata the payload fields
// order: the input register captures each item, then the decode step loads
//   the result register from the input register
// throughput: one item per cycle while m_axis_tready stays high; the decode step
//   is a single pass of byte classification plus small counter updates between the two registers
// stalls: while the receiver holds m_axis_tready low the result register
//   holds; the input register still takes one more item, then s_axis_tready
//   drops until the result register frees up
// reset: rst is synchronous, active high; clears both registers' valid flags
//   and all pattern state (no pattern open, periods and counters zero)
// ----------------------------------------------------------------------------
module tracker_pattern_row_decoder #(
  parameter int MAX_ROWS = trpd_pkg::TRPD_MAX_ROWS,
  parameter int MIN_ROWS = trpd_pkg::TRPD_MIN_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [3:0]  s_axis_tuser,   // [1:0] cmd, [3:2] channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] value, [15:8] envelope_period, [16] channel_done, [19:17] need_mask,
  // [26:20] row_number, [33:27] pattern_length, [39:34] zero
  output logic [39:0]      m_axis_tdata,
  output logic [3:0]       m_axis_tuser    // [3:0] kind
);
  import trpd_pkg::*;

  // input register
  logic       in_valid;
  logic [1:0] in_cmd;
  logic [1:0] in_ch;
  logic [7:0] in_byte;

  // result register
  result_t    res;
  result_t    core_res;

  logic       out_free;
  logic       step;
  logic       in_take;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  // payload captured on every input transfer
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd  <= s_axis_tuser[1:0];
      in_ch   <= s_axis_tuser[3:2];
      in_byte <= s_axis_tdata;
    end
  end

  trpd_core #(
    .MAX_ROWS (MAX_ROWS),
    .MIN_ROWS (MIN_ROWS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cmd       (in_cmd),
    .channel   (in_ch),
    .data_byte (in_byte),
    .result    (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= core_res;
    end
  end

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {6'd0, res.pattern_length, res.row_number, res.need_mask,
                         res.channel_done, res.env_period, res.value};

  // an item in the input register moves on whenever the result slot is free
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_free) |=> m_axis_tvalid) else $error("result not loaded");

  // the input register never takes a new item while its old one is stuck
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_free) |-> !s_axis_tready) else $error("input overwrite");

  // an unpaired stall keeps the held item in the input register
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_free) |=> in_valid) else $error("input item dropped");

endmodule
`default_nettype wire

[rtl/trpd_classify.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trpd_classify: data byte classifier
// Maps one ordinary pattern byte to its kind, value and side effects.
// ----------------------------------------------------------------------------
module trpd_classify (
  input  wire logic [7:0]           data_byte,
  output trpd_pkg::byte_class_t     cls
);
  import trpd_pkg::*;

  always_comb begin
    cls = '{kind: K_PERIOD, value: 8'(data_byte - B_PERIOD_BASE), done: 1'b0,
            env_type: 1'b0, period_set: 1'b1};
    if (data_byte <= B_NOTE_LAST) begin
      cls = '{kind: K_NOTE, value: data_byte, done: 1'b1,
              env_type: 1'b0, period_set: 1'b0};
    end else if (data_byte <= B_SAMPLE_LAST) begin
      cls = '{kind: K_SAMPLE, value: 8'(data_byte - B_SAMPLE_BASE), done: 1'b0,
              env_type: 1'b0, period_set: 1'b0};
    end else if (data_byte <= B_ORN_LAST) begin
      cls = '{kind: K_ORNAMENT, value: 8'(data_byte - B_ORN_BASE), done: 1'b0,
              env_type: 1'b0, period_set: 1'b0};
    end else if (data_byte == B_REST) begin
      cls = '{kind: K_REST, value: 8'd0, done: 1'b1,
              env_type: 1'b0, period_set: 1'b0};
    end else if (data_byte == B_EMPTY) begin
      cls = '{kind: K_EMPTY, value: 8'd0, done: 1'b1,
              env_type: 1'b0, period_set: 1'b0};
    end else if (data_byte == B_ORN_ZERO) begin
      cls = '{kind: K_ORNAMENT, value: 8'd0, done: 1'b0,
              env_type: 1'b0, period_set: 1'b0};
    end else if (data_byte <= B_ENV_LAST) begin
      // ornament 0 with an envelope type, period byte follows
      cls = '{kind: K_ENVWAIT, value: 8'(data_byte - B_REST), done: 1'b0,
              env_type: 1'b1, period_set: 1'b0};
    end
  end

endmodule
`default_nettype wire

[rtl/trpd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trpd_core: pattern state and single-pass step
// Holds the per-channel periods and counters and the row state, and forms
// the result of one item from the registered input in one pass.
// ----------------------------------------------------------------------------
module trpd_core #(
  parameter int MAX_ROWS = trpd_pkg::TRPD_MAX_ROWS,
  parameter int MIN_ROWS = trpd_pkg::TRPD_MIN_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [1:0]        cmd,
  input  wire logic [1:0]        channel,
  input  wire logic [7:0]        data_byte,
  output trpd_pkg::result_t      result
);
  import trpd_pkg::*;

  localparam int RCW = $clog2(MAX_ROWS + 1);

  logic [7:0]        skip_period [NUM_CH];
  logic [7:0]        skip_counter [NUM_CH];
  logic [NUM_CH-1:0] pending;
  logic              awaiting;
  logic [3:0]        held_env;
  logic              first_byte;
  logic [RCW-1:0]    row_count;
  logic              pattern_open;

  logic [7:0]        skip_period_next [NUM_CH];
  logic [7:0]        skip_counter_next [NUM_CH];
  logic [NUM_CH-1:0] pending_next;
  logic              awaiting_next;
  logic [3:0]        held_env_next;
  logic              first_byte_next;
  logic [RCW-1:0]    row_count_next;
  logic              pattern_open_next;

  byte_class_t       cls;
  logic [NUM_CH-1:0] ch_hot;
  logic [NUM_CH-1:0] lowest;
  logic              data_ok;
  logic              is_first;
  logic [RCW-1:0]    cur_row;

  trpd_classify u_classify (
    .data_byte (data_byte),
    .cls       (cls)
  );

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      ch_hot[i] = (channel == 2'(i));
    end
  end

  assign lowest   = pending & NUM_CH'(~pending + NUM_CH'(1));
  assign data_ok  = pattern_open && (ch_hot != '0) && (lowest == ch_hot);
  assign is_first = ch_hot[0] && first_byte;
  assign cur_row  = (row_count != '0) ? row_count - RCW'(1) : '0;

  always_comb begin
    skip_period_next  = skip_period;
    skip_counter_next = skip_counter;
    pending_next      = pending;
    awaiting_next     = awaiting;
    held_env_next     = held_env;
    first_byte_next   = first_byte;
    row_count_next    = row_count;
    pattern_open_next = pattern_open;
    result.kind           = K_UNEXPECTED;
    result.value          = '0;
    result.env_period     = '0;
    result.channel_done   = 1'b0;
    result.pattern_length = '0;

    unique case (cmd)
      CMD_BEGIN: begin
        for (int i = 0; i < NUM_CH; i++) begin
          skip_period_next[i]  = '0;
          skip_counter_next[i] = '0;
        end
        pending_next      = '0;
        awaiting_next     = 1'b0;
        held_env_next     = '0;
        first_byte_next   = 1'b0;
        row_count_next    = '0;
        pattern_open_next = 1'b1;
        result.kind       = K_STARTED;
      end
      CMD_ROW: begin
        if (pattern_open && pending == '0 && !awaiting) begin
          if (32'(row_count) >= 32'(MAX_ROWS)) begin
            pattern_open_next = 1'b0;
            result.kind       = K_FULL;
          end else begin
            row_count_next = row_count + RCW'(1);
            for (int i = 0; i < NUM_CH; i++) begin
              if (skip_counter[i] != '0) begin
                skip_counter_next[i] = skip_counter[i] - 8'd1;
              end else begin
                pending_next[i] = 1'b1;
              end
            end
            first_byte_next = pending_next[0];
            result.kind     = K_ROW;
          end
        end
      end
      CMD_DATA: begin
        if (data_ok) begin
          if (ch_hot[0]) begin
            first_byte_next = 1'b0;
          end
          if (awaiting) begin
            awaiting_next     = 1'b0;
            result.kind       = K_ENVELOPE;
            result.value      = 8'(held_env);
            result.env_period = data_byte;
          end else if (is_first && data_byte == B_END) begin
            pattern_open_next = 1'b0;
            pending_next      = '0;
            result.kind       = K_END;
            result.pattern_length = (32'(cur_row) > 32'(MIN_ROWS)) ?
                                    ROW_W'(cur_row) : ROW_W'(MIN_ROWS);
          end else begin
            result.kind         = cls.kind;
            result.value        = cls.value;
            result.channel_done = cls.done;
            if (cls.env_type) begin
              held_env_next = cls.value[3:0];
              awaiting_next = 1'b1;
            end
            for (int i = 0; i < NUM_CH; i++) begin
              if (ch_hot[i] && cls.period_set) begin
                skip_period_next[i] = cls.value;
              end
              if (ch_hot[i] && cls.done) begin
                pending_next[i]      = 1'b0;
                skip_counter_next[i] = skip_period[i];
              end
            end
          end
        end
      end
      default: begin
        result.kind = K_UNEXPECTED;
      end
    endcase

    result.need_mask  = pending_next;
    result.row_number = (row_count_next != '0) ?
                        ROW_W'(row_count_next - RCW'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        skip_period[i]  <= '0;
        skip_counter[i] <= '0;
      end
      pending      <= '0;
      awaiting     <= 1'b0;
      held_env     <= '0;
      first_byte   <= 1'b0;
      row_count    <= '0;
      pattern_open <= 1'b0;
    end else if (step) begin
      skip_period  <= skip_period_next;
      skip_counter <= skip_counter_next;
      pending      <= pending_next;
      awaiting     <= awaiting_next;
      held_env     <= held_env_next;
      first_byte   <= first_byte_next;
      row_count    <= row_count_next;
      pattern_open <= pattern_open_next;
    end
  end

  // an envelope period can only be owed inside an open pattern
  a_await_open: assert property (@(posedge clk) disable iff (rst)
    awaiting |-> pattern_open) else $error("envelope wait outside pattern");

  // channels owe bytes only inside an open pattern
  a_pending_open: assert property (@(posedge clk) disable iff (rst)
    (pending != '0) |-> pattern_open) else $error("pending channels outside pattern");

  // row counter never runs past the pattern limit
  a_row_limit: assert property (@(posedge clk) disable iff (rst)
    32'(row_count) <= 32'(MAX_ROWS)) else $error("row count beyond limit");

  // the first-byte flag only stands while channel 0 still owes its bytes
  a_first_pending: assert property (@(posedge clk) disable iff (rst)
    first_byte |-> pending[0]) else $error("first byte flag without channel 0");

endmodule
`default_nettype wire
